[sv/stl_pkg.sv]
`timescale 1ns / 1ps
package stl_pkg;

   localparam int POSITION_BITS_DEFAULT   = 16;
   localparam int KEYWORD_MAX_LEN_DEFAULT = 7;
   localparam int KEYWORD_COUNT           = 16;

   // lexer modes
   localparam logic [4:0] M_IDLE    = 5'd0;
   localparam logic [4:0] M_IDENT   = 5'd1;
   localparam logic [4:0] M_NUM     = 5'd2;
   localparam logic [4:0] M_SLASH   = 5'd3;
   localparam logic [4:0] M_LINE    = 5'd4;
   localparam logic [4:0] M_BLOCK   = 5'd5;
   localparam logic [4:0] M_R       = 5'd6;
   localparam logic [4:0] M_DOLLAR  = 5'd7;
   localparam logic [4:0] M_EQ      = 5'd8;
   localparam logic [4:0] M_BANG    = 5'd9;
   localparam logic [4:0] M_LT      = 5'd10;
   localparam logic [4:0] M_GT      = 5'd11;
   localparam logic [4:0] M_SOPEN   = 5'd12;
   localparam logic [4:0] M_SPLAIN  = 5'd13;
   localparam logic [4:0] M_STRIPLE = 5'd14;

   // token kinds
   localparam logic [5:0] K_IDENT  = 6'd16;
   localparam logic [5:0] K_NUMBER = 6'd17;
   localparam logic [5:0] K_STRING = 6'd18;
   localparam logic [5:0] K_ASSIGN = 6'd19;
   localparam logic [5:0] K_EQ     = 6'd20;
   localparam logic [5:0] K_NE     = 6'd21;
   localparam logic [5:0] K_LT     = 6'd22;
   localparam logic [5:0] K_LE     = 6'd23;
   localparam logic [5:0] K_GT     = 6'd24;
   localparam logic [5:0] K_GE     = 6'd25;
   localparam logic [5:0] K_PLUS   = 6'd26;
   localparam logic [5:0] K_MINUS  = 6'd27;
   localparam logic [5:0] K_STAR   = 6'd28;
   localparam logic [5:0] K_SLASH  = 6'd29;
   localparam logic [5:0] K_PCT    = 6'd30;
   localparam logic [5:0] K_AMP    = 6'd31;
   localparam logic [5:0] K_BAR    = 6'd32;
   localparam logic [5:0] K_CARET  = 6'd33;
   localparam logic [5:0] K_TILDE  = 6'd34;
   localparam logic [5:0] K_LPAREN = 6'd35;
   localparam logic [5:0] K_RPAREN = 6'd36;
   localparam logic [5:0] K_LBRACE = 6'd37;
   localparam logic [5:0] K_RBRACE = 6'd38;
   localparam logic [5:0] K_LBRACK = 6'd39;
   localparam logic [5:0] K_RBRACK = 6'd40;
   localparam logic [5:0] K_COMMA  = 6'd41;
   localparam logic [5:0] K_DOT    = 6'd42;
   localparam logic [5:0] K_COLON  = 6'd43;
   localparam logic [5:0] K_EOF    = 6'd44;

   localparam logic [1:0] SK_PLAIN  = 2'd0;
   localparam logic [1:0] SK_TRIPLE = 2'd1;
   localparam logic [1:0] SK_RAW    = 2'd2;
   localparam logic [1:0] SK_INTERP = 2'd3;

   // keyword text, first char in the lowest byte, zero padded
   localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
      64'h00000000636e7566, 64'h0000000000746e69, 64'h0000000000727473,
      64'h0000000000006669, 64'h00000000_65736c65, 64'h000000656c696877,
      64'h0000000000726f66, 64'h0068636165726f66, 64'h0000000065757274,
      64'h00000065736c6166, 64'h0000000000646e61, 64'h000000000000726f,
      64'h0000000000726f78, 64'h0000000000746f6e, 64'h00006e7275746572,
      64'h0000000070_6f7473 };
   localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
      4'd4, 4'd3, 4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd7,
      4'd4, 4'd5, 4'd3, 4'd2, 4'd3, 4'd3, 4'd6, 4'd4 };

   // one token leaving the step logic
   typedef struct packed {
      logic [5:0] kind;
      logic [1:0] skind;
      logic       err;
   } tok_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // single-character operators and delimiters, 0 when none
   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h2b:   k = K_PLUS;
         8'h2d:   k = K_MINUS;
         8'h2a:   k = K_STAR;
         8'h25:   k = K_PCT;
         8'h26:   k = K_AMP;
         8'h7c:   k = K_BAR;
         8'h5e:   k = K_CARET;
         8'h7e:   k = K_TILDE;
         8'h28:   k = K_LPAREN;
         8'h29:   k = K_RPAREN;
         8'h7b:   k = K_LBRACE;
         8'h7d:   k = K_RBRACE;
         8'h5b:   k = K_LBRACK;
         8'h5d:   k = K_RBRACK;
         8'h2c:   k = K_COMMA;
         8'h2e:   k = K_DOT;
         8'h3a:   k = K_COLON;
         default: k = 6'd0;
      endcase
      return k;
   endfunction

endpackage

[sv/stl_keyword_match.sv]
`timescale 1ns / 1ps
// matches the held identifier characters against the keyword table
module stl_keyword_match #(
   parameter int KEYWORD_MAX_LEN = stl_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
   input  logic [KEYWORD_MAX_LEN*8-1:0] chars,
   input  logic [3:0]                   ident_len,
   output logic [5:0]                   kind
);
   always_comb begin
      kind = stl_pkg::K_IDENT;
      for (int k = stl_pkg::KEYWORD_COUNT - 1; k >= 0; k--) begin
         logic hit;
         hit = (ident_len == stl_pkg::KW_LEN[k])
               && (int'(stl_pkg::KW_LEN[k]) <= KEYWORD_MAX_LEN);
         for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
            if (i < int'(stl_pkg::KW_LEN[k]) && chars[i*8 +: 8] != stl_pkg::KW_TEXT[k][i*8 +: 8])
               hit = 1'b0;
         end
         if (hit) kind = 6'(k);
      end
   end
endmodule

[sv/stl_core.sv]
`timescale 1ns / 1ps
// per-byte lexer step: next state and up to two tokens
module stl_core #(
   parameter int POSITION_BITS   = stl_pkg::POSITION_BITS_DEFAULT,
   parameter int KEYWORD_MAX_LEN = stl_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       action,
   input  logic [7:0]                 ch,
   output logic                       out_n0,
   output logic                       out_n1,
   output stl_pkg::tok_type           tok0,
   output stl_pkg::tok_type           tok1,
   output logic [POSITION_BITS-1:0]   start0,
   output logic [POSITION_BITS-1:0]   len0,
   output logic [POSITION_BITS-1:0]   start1,
   output logic [POSITION_BITS-1:0]   len1
);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] TWO = POSITION_BITS'(2);

   logic [4:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, tstart_ff, tstart_in;
   logic [KEYWORD_MAX_LEN*8-1:0] kw_ff, kw_in;
   logic [3:0]               ilen_ff, ilen_in;
   logic [1:0]               pq_ff, pq_in, sk_ff, sk_in;
   logic                     star_ff, star_in, fin_ff, fin_in;
   logic [5:0]               kw_kind;

   stl_keyword_match #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_match (
      .chars(kw_ff), .ident_len(ilen_ff), .kind(kw_kind));

   function automatic logic [POSITION_BITS-1:0] inc_sat(input logic [POSITION_BITS-1:0] p);
      return (p == POS_MAX) ? p : p + ONE;
   endfunction

   function automatic logic [POSITION_BITS-1:0] span(input logic [POSITION_BITS-1:0] f,
                                                     input logic [POSITION_BITS-1:0] t);
      return (t > f) ? t - f : '0;
   endfunction

   always_comb begin
      logic [7:0] c;
      logic [POSITION_BITS-1:0] p;
      logic [4:0] m;
      logic go_idle;
      logic [5:0] sk1;
      c = ch;
      p = pos_ff;
      m = mode_ff;
      go_idle = 1'b0;
      sk1 = 6'd0;
      mode_in = mode_ff; pos_in = pos_ff; tstart_in = tstart_ff; kw_in = kw_ff;
      ilen_in = ilen_ff; pq_in = pq_ff; sk_in = sk_ff; star_in = star_ff; fin_in = fin_ff;
      out_n0 = 1'b0; out_n1 = 1'b0;
      tok0 = '0; tok1 = '0;
      start0 = tstart_ff; len0 = '0; start1 = p; len1 = '0;
      if (step && !fin_ff) begin
         if (action || c == 8'd0) begin
            // end of source: pending token, then end of file
            out_n0 = 1'b1;
            case (m)
               stl_pkg::M_R, stl_pkg::M_IDENT: begin
                  tok0.kind = kw_kind; len0 = span(tstart_ff, p);
               end
               stl_pkg::M_NUM: begin
                  tok0.kind = stl_pkg::K_NUMBER; len0 = span(tstart_ff, p);
               end
               stl_pkg::M_SLASH: begin tok0.kind = stl_pkg::K_SLASH; len0 = ONE; end
               stl_pkg::M_EQ:    begin tok0.kind = stl_pkg::K_ASSIGN; len0 = ONE; end
               stl_pkg::M_LT:    begin tok0.kind = stl_pkg::K_LT; len0 = ONE; end
               stl_pkg::M_GT:    begin tok0.kind = stl_pkg::K_GT; len0 = ONE; end
               stl_pkg::M_SOPEN: begin tok0.kind = stl_pkg::K_STRING; tok0.skind = sk_ff; end
               stl_pkg::M_SPLAIN, stl_pkg::M_STRIPLE: begin
                  tok0.kind = stl_pkg::K_STRING; tok0.skind = sk_ff;
                  len0 = span(tstart_ff, p);
               end
               default: out_n0 = 1'b0;
            endcase
            out_n1 = 1'b1;
            tok1.kind = stl_pkg::K_EOF;
            tok1.err = (m == stl_pkg::M_BLOCK);
            mode_in = stl_pkg::M_IDLE;
            fin_in = 1'b1;
         end else begin
            pos_in = inc_sat(p);
            case (m)
               stl_pkg::M_R, stl_pkg::M_IDENT: begin
                  if (m == stl_pkg::M_R && c == 8'h22) begin
                     mode_in = stl_pkg::M_SOPEN; sk_in = stl_pkg::SK_RAW;
                     pq_in = '0; tstart_in = inc_sat(p);
                  end else if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)) begin
                     mode_in = stl_pkg::M_IDENT;
                     for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                        if (ilen_ff == 4'(i)) kw_in[i*8 +: 8] = c;
                     if (int'(ilen_ff) <= KEYWORD_MAX_LEN) ilen_in = ilen_ff + 4'd1;
                  end else begin
                     out_n0 = 1'b1; tok0.kind = kw_kind; len0 = span(tstart_ff, p);
                     go_idle = 1'b1;
                  end
               end
               stl_pkg::M_NUM: begin
                  if (!stl_pkg::is_digit(c)) begin
                     out_n0 = 1'b1; tok0.kind = stl_pkg::K_NUMBER;
                     len0 = span(tstart_ff, p); go_idle = 1'b1;
                  end
               end
               stl_pkg::M_SLASH: begin
                  if (c == 8'h2f) mode_in = stl_pkg::M_LINE;
                  else if (c == 8'h2a) begin mode_in = stl_pkg::M_BLOCK; star_in = 1'b0; end
                  else begin
                     out_n0 = 1'b1; tok0.kind = stl_pkg::K_SLASH; len0 = ONE;
                     go_idle = 1'b1;
                  end
               end
               stl_pkg::M_LINE: if (c == 8'h0a) mode_in = stl_pkg::M_IDLE;
               stl_pkg::M_BLOCK: begin
                  if (star_ff && c == 8'h2f) begin
                     mode_in = stl_pkg::M_IDLE; star_in = 1'b0;
                  end else star_in = (c == 8'h2a);
               end
               stl_pkg::M_DOLLAR: begin
                  if (c == 8'h22) begin
                     mode_in = stl_pkg::M_SOPEN; sk_in = stl_pkg::SK_INTERP;
                     pq_in = '0; tstart_in = inc_sat(p);
                  end else go_idle = 1'b1;
               end
               stl_pkg::M_EQ, stl_pkg::M_BANG, stl_pkg::M_LT, stl_pkg::M_GT: begin
                  if (c == 8'h3d) begin
                     out_n0 = 1'b1; len0 = TWO; mode_in = stl_pkg::M_IDLE;
                     case (m)
                        stl_pkg::M_EQ:   tok0.kind = stl_pkg::K_EQ;
                        stl_pkg::M_BANG: tok0.kind = stl_pkg::K_NE;
                        stl_pkg::M_LT:   tok0.kind = stl_pkg::K_LE;
                        default:         tok0.kind = stl_pkg::K_GE;
                     endcase
                  end else begin
                     out_n0 = (m != stl_pkg::M_BANG); len0 = ONE;
                     case (m)
                        stl_pkg::M_EQ: tok0.kind = stl_pkg::K_ASSIGN;
                        stl_pkg::M_LT: tok0.kind = stl_pkg::K_LT;
                        default:       tok0.kind = stl_pkg::K_GT;
                     endcase
                     go_idle = 1'b1;
                  end
               end
               stl_pkg::M_SOPEN: begin
                  if (c == 8'h22) begin
                     if (pq_ff == 2'd0) pq_in = 2'd1;
                     else begin
                        mode_in = stl_pkg::M_STRIPLE; pq_in = '0;
                        tstart_in = inc_sat(p);
                        if (sk_ff == stl_pkg::SK_PLAIN) sk_in = stl_pkg::SK_TRIPLE;
                     end
                  end else if (pq_ff == 2'd0) mode_in = stl_pkg::M_SPLAIN;
                  else begin
                     out_n0 = 1'b1; tok0.kind = stl_pkg::K_STRING; tok0.skind = sk_ff;
                     pq_in = '0; go_idle = 1'b1;
                  end
               end
               stl_pkg::M_SPLAIN: begin
                  if (c == 8'h22) begin
                     out_n0 = 1'b1; tok0.kind = stl_pkg::K_STRING; tok0.skind = sk_ff;
                     len0 = span(tstart_ff, p); mode_in = stl_pkg::M_IDLE;
                  end
               end
               stl_pkg::M_STRIPLE: begin
                  if (c != 8'h22) pq_in = '0;
                  else if (pq_ff >= 2'd2) begin
                     out_n0 = 1'b1; tok0.kind = stl_pkg::K_STRING; tok0.skind = sk_ff;
                     len0 = span(tstart_ff, span(TWO, p));
                     pq_in = '0; mode_in = stl_pkg::M_IDLE;
                  end else pq_in = pq_ff + 2'd1;
               end
               default: go_idle = 1'b1;
            endcase
            // dispatch of the current byte from idle
            if (go_idle) begin
               mode_in = stl_pkg::M_IDLE;
               tstart_in = p;
               sk1 = stl_pkg::single_kind(c);
               if (stl_pkg::is_space(c)) begin
               end else if (sk1 != 6'd0) begin
                  out_n1 = 1'b1; tok1.kind = sk1; start1 = p; len1 = ONE;
               end else begin
                  case (c)
                     8'h2f: mode_in = stl_pkg::M_SLASH;
                     8'h72: begin
                        mode_in = stl_pkg::M_R; kw_in[7:0] = c; ilen_in = 4'd1;
                     end
                     8'h24: mode_in = stl_pkg::M_DOLLAR;
                     8'h3d: mode_in = stl_pkg::M_EQ;
                     8'h21: mode_in = stl_pkg::M_BANG;
                     8'h3c: mode_in = stl_pkg::M_LT;
                     8'h3e: mode_in = stl_pkg::M_GT;
                     8'h22: begin
                        mode_in = stl_pkg::M_SOPEN; sk_in = stl_pkg::SK_PLAIN;
                        pq_in = '0; tstart_in = inc_sat(p);
                     end
                     default: begin
                        if (stl_pkg::is_alpha(c)) begin
                           mode_in = stl_pkg::M_IDENT; kw_in[7:0] = c; ilen_in = 4'd1;
                        end else if (stl_pkg::is_digit(c)) mode_in = stl_pkg::M_NUM;
                     end
                  endcase
               end
            end
         end
      end
   end

   // lexer state
   always_ff @(posedge clock) begin
      kw_ff <= kw_in;
      if (reset) begin
         mode_ff <= stl_pkg::M_IDLE; pos_ff <= '0; tstart_ff <= '0; ilen_ff <= '0;
         pq_ff <= '0; sk_ff <= '0; star_ff <= 1'b0; fin_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in; pos_ff <= pos_in; tstart_ff <= tstart_in; ilen_ff <= ilen_in;
         pq_ff <= pq_in; sk_ff <= sk_in; star_ff <= star_in; fin_ff <= fin_in;
      end
   end

   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff) else $error("finished flag dropped");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> mode_ff == stl_pkg::M_IDLE) else $error("mode moved after end");
   a_pq_range: assert property (@(posedge clock) disable iff (reset)
      pq_ff != 2'd3) else $error("quote count overflow");
endmodule

[sv/script_token_lexer.sv]
`timescale 1ns / 1ps
// script_token_lexer: streaming lexer for script source
// req channel: one request per source byte (tuser = end of source, tdata = byte);
// a zero byte or tuser high ends the source.
// rsp channel: one token per transfer; tdata carries kind, start, length,
// string kind and error; tlast marks the final token caused by a request.
// a request causes zero, one or two tokens: two when a token ends and the byte
// itself is a single-character token, or at end (pending token plus end of file).
// the first token of a request appears in the cycle after the request is taken.
// throughput: one byte per cycle while a request makes at most one token and the
// receiver does not stall; a request making two tokens holds req_tready low while
// the second token drains from its holding register.
// reset (synchronous, active high) clears position, mode and the output stage.
// when the receiver stalls the result register holds and req_tready falls once
// it cannot take another request's tokens; nothing is lost.
// after the end of file token all further requests are taken and dropped
// until reset.
module script_token_lexer #(
   parameter int POSITION_BITS   = stl_pkg::POSITION_BITS_DEFAULT,
   parameter int KEYWORD_MAX_LEN = stl_pkg::KEYWORD_MAX_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // token_kind, start_pos, length, string_kind, error, pad
   output logic        rsp_tlast    // last_of_run
);
   localparam int RW = 6 + 16 + 16 + 2 + 1;

   logic step, n0, n1;
   stl_pkg::tok_type t0, t1;
   logic [POSITION_BITS-1:0] s0, l0, s1, l1;
   logic [RW-1:0] r0, r1;
   logic [RW-1:0] out_ff, out_in, hold_ff, hold_in;
   logic out_v_ff, out_v_in, out_l_ff, out_l_in, hold_v_ff, hold_v_in;

   stl_core #(.POSITION_BITS(POSITION_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_core (
      .clock(clock), .reset(reset), .step(step), .action(req_tuser), .ch(req_tdata),
      .out_n0(n0), .out_n1(n1), .tok0(t0), .tok1(t1),
      .start0(s0), .len0(l0), .start1(s1), .len1(l1));

   // pack a result word, low field first
   assign r0 = {t0.err, t0.skind, 16'(l0), 16'(s0), t0.kind};
   assign r1 = {t1.err, t1.skind, 16'(l1), 16'(s1), t1.kind};

   // accept when the output register frees this cycle and nothing is held
   assign req_tready = !hold_v_ff && (!out_v_ff || rsp_tready);
   assign step = req_tvalid && req_tready;

   always_comb begin
      out_in = out_ff; out_v_in = out_v_ff; out_l_in = out_l_ff;
      hold_in = hold_ff; hold_v_in = hold_v_ff;
      if (rsp_tready || !out_v_ff) begin
         out_v_in = 1'b0;
         if (hold_v_ff) begin
            out_in = hold_ff; out_v_in = 1'b1; out_l_in = 1'b1; hold_v_in = 1'b0;
         end else if (step && (n0 || n1)) begin
            out_v_in = 1'b1;
            if (n0) begin
               out_in = r0; out_l_in = !n1;
               if (n1) begin hold_in = r1; hold_v_in = 1'b1; end
            end else begin
               out_in = r1; out_l_in = 1'b1;
            end
         end
      end
   end

   // result register and second-token holding register
   always_ff @(posedge clock) begin
      out_ff <= out_in; out_l_ff <= out_l_in; hold_ff <= hold_in;
      if (reset) begin
         out_v_ff <= 1'b0; hold_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in; hold_v_ff <= hold_v_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {7'd0, out_ff};
   assign rsp_tlast = out_l_ff;

   a_hold_needs_out: assert property (@(posedge clock) disable iff (reset)
      hold_v_ff |-> out_v_ff) else $error("held token without output");
   a_hold_not_last: assert property (@(posedge clock) disable iff (reset)
      hold_v_ff |-> !out_l_ff) else $error("first of pair marked last");
   a_no_step_hold: assert property (@(posedge clock) disable iff (reset)
      hold_v_ff |-> !req_tready) else $error("request taken while holding");
endmodule
